/* design/cholesky_trailing_pair_permute_assert.svh */
// assertion macros for the cholesky trailing pair permute block
// expects clk and arst_n in the scope where a macro is used
`ifndef CHOLESKY_TRAILING_PAIR_PERMUTE_ASSERT_SVH
`define CHOLESKY_TRAILING_PAIR_PERMUTE_ASSERT_SVH

// same-cycle implication
`define CTPP_ASSERT_NOW(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("assertion failed");

// next-cycle implication
`define CTPP_ASSERT_NEXT(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("assertion failed");

`endif

/* design/ctpp_pkg.sv */
// shared types for the cholesky trailing pair permute block
// used by the top level and the shared arithmetic unit
package ctpp_pkg;

	localparam int WORD_W = 32;

	typedef enum logic {
		OP_SQRT = 1'b0,
		OP_DIV  = 1'b1
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef struct packed {
		logic done;
		logic zero;
	} alu_sts_t;

endpackage

/* design/cholesky_trailing_pair_permute.sv */
// Cholesky trailing pair permute. Load words (func 0) write one entry of the upper
// factor U into the source memory. A query word (func 1) names i < j: the block
// copies U transposed into a working memory, then for each adjacent symmetric swap
// (up to 2p-4 of them) swaps rows and columns through the working memory, which
// has one read and one write port, forms a*a + b*b on the shared multiplier, takes
// a 32-step bit-serial root and two 32-step divisions for c and s, and rotates the
// rows below. The time of a query is set by the serial root and divider and by the
// two memory ports; the block takes no word meanwhile. After reset a clearing pass
// zeroes the source memory before the first word is taken. A finished result waits
// in an output register, so the next word is accepted while it is still stalled.
// depends on ctpp_pkg and ctpp_alu
module cholesky_trailing_pair_permute #(
	parameter int MAX_DIM = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_data,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic        func,
	input  logic [2:0]  row,
	input  logic [2:0]  col,
	input  logic signed [31:0] value,
	input  logic [2:0]  first_index,
	input  logic [2:0]  second_index,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic signed [31:0] diag_first,
	output logic signed [31:0] off_diag,
	output logic signed [31:0] diag_second,
	output logic        ok
);
	import ctpp_pkg::*;

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);
	// counters hold p (4 bits) and MAX_DIM, plus headroom for k+2
	localparam int CB    = ($clog2(MAX_DIM + 1) > 4) ? $clog2(MAX_DIM + 1) : 4;
	localparam int CW    = CB + 1;
	localparam int NS    = 35;

	typedef enum logic [NS-1:0] {
		S_CLR  = 35'h1 << 0,  S_IDLE = 35'h1 << 1,  S_CP   = 35'h1 << 2,
		S_CPE  = 35'h1 << 3,  S_NEXT = 35'h1 << 4,  S_SR0  = 35'h1 << 5,
		S_SR1  = 35'h1 << 6,  S_SR2  = 35'h1 << 7,  S_SR3  = 35'h1 << 8,
		S_RA   = 35'h1 << 9,  S_RB   = 35'h1 << 10, S_MA   = 35'h1 << 11,
		S_MB   = 35'h1 << 12, S_MC   = 35'h1 << 13, S_SQ   = 35'h1 << 14,
		S_SQW  = 35'h1 << 15, S_DA   = 35'h1 << 16, S_DAW  = 35'h1 << 17,
		S_DB   = 35'h1 << 18, S_DBW  = 35'h1 << 19, S_WR0  = 35'h1 << 20,
		S_WR1  = 35'h1 << 21, S_RX   = 35'h1 << 22, S_RY   = 35'h1 << 23,
		S_M1   = 35'h1 << 24, S_M2   = 35'h1 << 25, S_M3   = 35'h1 << 26,
		S_M4   = 35'h1 << 27, S_M5   = 35'h1 << 28, S_M6   = 35'h1 << 29,
		S_F1   = 35'h1 << 30, S_F2   = 35'h1 << 31, S_F3   = 35'h1 << 32,
		S_F4   = 35'h1 << 33, S_DONE = 35'h1 << 34
	} state_t;

	function automatic logic [AW-1:0] adr(input logic [CW-1:0] r, input logic [CW-1:0] c);
		return AW'(r) * AW'(MAX_DIM) + AW'(c);
	endfunction

	// round from q.46 to q16.16, ties away from zero, then saturate
	function automatic logic [31:0] rnd_sat(input logic signed [63:0] v);
		logic [63:0]        m;
		logic [34:0]        q;
		logic signed [35:0] s;
		m = v[63] ? 64'(-v) : 64'(v);
		q = 35'((m + 64'd536870912) >> 30);
		s = v[63] ? -$signed({1'b0, q}) : $signed({1'b0, q});
		if (s > $signed(36'sd2147483647)) return 32'h7fff_ffff;
		if (s < -$signed(36'sd2147483648)) return 32'h8000_0000;
		return s[31:0];
	endfunction

	// (|x| << 30) + r/2, the rounded numerator of x/r in q2.30
	function automatic logic [63:0] div_num(input logic signed [31:0] x,
		input logic [32:0] r);
		logic signed [32:0] ax;
		ax = x[31] ? -{x[31], x} : {x[31], x};
		return {2'b00, ax[31:0], 30'b0} + {32'b0, r[32:1]};
	endfunction

	state_t             st_q;
	logic [3:0]         size_q;
	logic [AW-1:0]      clr_q;
	logic [CW-1:0]      i_q, j_q, k_q, t_q, cr_q, cc_q;
	logic               pha_q, rowm_q, fail_q;
	logic               cp_s1;
	logic [AW-1:0]      cp_waddr_s1;
	logic signed [31:0] a_q, b_q, x_q, y_q, c_q, s_q;
	logic [32:0]        r_q;
	logic [63:0]        sum_q;
	logic signed [63:0] acc_q, accx_q;
	logic [31:0]        d1_q, od_q, d2_q;
	logic               rsp_valid_q, ok_q;
	logic [31:0]        out_d1_q, out_od_q, out_d2_q;

	logic [31:0]        src_mem [DEPTH];
	logic [31:0]        wk_mem  [DEPTH];
	logic [31:0]        src_rd_q, wk_rd_q;

	logic [CW-1:0]      p_w, pm1, pm2, kp1, i_w, j_w;
	logic [AW-1:0]      adr_a, adr_b, wk_raddr, wk_waddr, src_raddr;
	logic [31:0]        wk_wdata;
	logic               wk_we, load_w, take_w, q_ok, out_free;

	alu_req_t           alu_req;
	alu_sts_t           alu_sts;
	logic [63:0]        alu_num;
	logic signed [31:0] mul_x, mul_y;
	logic signed [63:0] prod;
	logic [32:0]        alu_res;

	assign p_w  = CW'(size_q);
	assign pm1  = p_w - CW'(1);
	assign pm2  = p_w - CW'(2);
	assign kp1  = k_q + CW'(1);
	assign i_w  = CW'(first_index);
	assign j_w  = CW'(second_index);

	// pair of entries under work: a row pair (k, k+1) across t, or a column pair
	assign adr_a = rowm_q ? adr(k_q, t_q) : adr(t_q, k_q);
	assign adr_b = rowm_q ? adr(kp1, t_q) : adr(t_q, kp1);

	assign req_stall = (st_q != S_IDLE);
	assign take_w    = req_valid && !req_stall;
	assign load_w    = take_w && !func && (CW'(row) < CW'(MAX_DIM))
		&& (CW'(col) < CW'(MAX_DIM));
	assign q_ok      = (p_w >= CW'(2)) && (p_w <= CW'(MAX_DIM)) && (i_w < j_w)
		&& (j_w < p_w);
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign src_raddr = adr(cc_q, cr_q);

	always_comb begin
		case (st_q)
			S_SR1, S_RB, S_RY: wk_raddr = adr_b;
			S_F1:              wk_raddr = adr(pm2, pm2);
			S_F2:              wk_raddr = adr(pm1, pm2);
			S_F3:              wk_raddr = adr(pm1, pm1);
			default:           wk_raddr = adr_a;
		endcase
	end

	always_comb begin
		wk_we    = 1'b1;
		wk_waddr = adr_a;
		wk_wdata = wk_rd_q;
		if (cp_s1) begin
			wk_waddr = cp_waddr_s1;
			wk_wdata = src_rd_q;
		end else begin
			case (st_q)
				S_SR2: wk_wdata = wk_rd_q;
				S_SR3: begin
					wk_waddr = adr_b;
					wk_wdata = x_q;
				end
				S_WR0: wk_wdata = (r_q[32] || r_q[31]) ? 32'h7fff_ffff : r_q[31:0];
				S_WR1: begin
					wk_waddr = adr_b;
					wk_wdata = '0;
				end
				S_M5:  wk_wdata = rnd_sat(accx_q);
				S_M6: begin
					wk_waddr = adr_b;
					wk_wdata = rnd_sat(acc_q);
				end
				default: wk_we = 1'b0;
			endcase
		end
	end

	// multiplier operands per step
	always_comb begin
		case (st_q)
			S_MA: begin
				mul_x = a_q;
				mul_y = a_q;
			end
			S_MB: begin
				mul_x = b_q;
				mul_y = b_q;
			end
			S_M1: begin
				mul_x = c_q;
				mul_y = x_q;
			end
			S_M2: begin
				mul_x = s_q;
				mul_y = y_q;
			end
			S_M3: begin
				mul_x = c_q;
				mul_y = y_q;
			end
			S_M4: begin
				mul_x = s_q;
				mul_y = x_q;
			end
			default: begin
				mul_x = x_q;
				mul_y = y_q;
			end
		endcase
	end

	assign alu_req.start = (st_q inside {S_SQ, S_DA, S_DB});
	assign alu_req.op    = (st_q == S_SQ) ? OP_SQRT : OP_DIV;
	always_comb begin
		case (st_q)
			S_DA:    alu_num = div_num(a_q, r_q);
			S_DB:    alu_num = div_num(b_q, r_q);
			default: alu_num = sum_q;
		endcase
	end

	ctpp_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.num    (alu_num),
		.den    (r_q),
		.mul_x  (mul_x),
		.mul_y  (mul_y),
		.prod   (prod),
		.res    (alu_res),
		.sts    (alu_sts)
	);

	// source memory: clearing pass after reset, then loads
	always_ff @(posedge clk) begin
		if (st_q == S_CLR) src_mem[clr_q] <= '0;
		else if (load_w) src_mem[adr(CW'(row), CW'(col))] <= value;
		src_rd_q <= src_mem[src_raddr];
	end

	always_ff @(posedge clk) begin
		if (wk_we) wk_mem[wk_waddr] <= wk_wdata;
		wk_rd_q <= wk_mem[wk_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= 4'd8;
		end else if (cfg_we) begin
			size_q <= cfg_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_CLR;
			clr_q       <= '0;
			cp_s1       <= 1'b0;
			rsp_valid_q <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			t_q         <= '0;
			cr_q        <= '0;
			cc_q        <= '0;
			pha_q       <= 1'b0;
			rowm_q      <= 1'b0;
			fail_q      <= 1'b0;
		end else begin
			cp_s1 <= (st_q == S_CP);
			// result word raised when done and free, held while stalled
			rsp_valid_q <= ((st_q == S_DONE) && out_free) || (rsp_valid_q && rsp_stall);
			case (st_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) st_q <= S_IDLE;
				end
				S_IDLE: begin
					if (take_w && func) begin
						i_q  <= i_w;
						j_q  <= j_w;
						cr_q <= '0;
						cc_q <= '0;
						if (q_ok) begin
							fail_q <= 1'b0;
							st_q   <= S_CP;
						end else begin
							fail_q <= 1'b1;
							st_q   <= S_DONE;
						end
					end
				end
				S_CP: begin
					// read source (c, r), written to working (r, c) next cycle
					if (cc_q == pm1) begin
						cc_q <= '0;
						cr_q <= cr_q + CW'(1);
						if (cr_q == pm1) st_q <= S_CPE;
					end else begin
						cc_q <= cc_q + CW'(1);
					end
				end
				S_CPE: begin
					k_q   <= j_q;
					pha_q <= 1'b1;
					st_q  <= S_NEXT;
				end
				S_NEXT: begin
					// first move j to the last place, then i to the one before
					if (pha_q) begin
						if (kp1 < p_w) begin
							t_q    <= '0;
							rowm_q <= 1'b1;
							st_q   <= S_SR0;
						end else begin
							pha_q <= 1'b0;
							k_q   <= i_q;
						end
					end else if (k_q + CW'(2) < p_w) begin
						t_q    <= '0;
						rowm_q <= 1'b1;
						st_q   <= S_SR0;
					end else begin
						st_q <= S_F1;
					end
				end
				S_SR0: st_q <= S_SR1;
				S_SR1: st_q <= S_SR2;
				S_SR2: st_q <= S_SR3;
				S_SR3: begin
					if (t_q + CW'(1) < p_w) begin
						t_q  <= t_q + CW'(1);
						st_q <= S_SR0;
					end else if (rowm_q) begin
						rowm_q <= 1'b0;
						t_q    <= '0;
						st_q   <= S_SR0;
					end else begin
						// column mode with t = k points at (k,k) and (k,k+1)
						t_q  <= k_q;
						st_q <= S_RA;
					end
				end
				S_RA:  st_q <= S_RB;
				S_RB:  st_q <= S_MA;
				S_MA:  st_q <= S_MB;
				S_MB:  st_q <= S_MC;
				S_MC:  st_q <= S_SQ;
				S_SQ:  st_q <= S_SQW;
				S_SQW: begin
					if (alu_sts.done) begin
						if (alu_sts.zero) begin
							fail_q <= 1'b1;
							st_q   <= S_DONE;
						end else begin
							st_q <= S_DA;
						end
					end
				end
				S_DA:  st_q <= S_DAW;
				S_DAW: if (alu_sts.done) st_q <= S_DB;
				S_DB:  st_q <= S_DBW;
				S_DBW: if (alu_sts.done) st_q <= S_WR0;
				S_WR0: st_q <= S_WR1;
				S_WR1: begin
					t_q  <= kp1;
					st_q <= S_RX;
				end
				S_RX:  st_q <= S_RY;
				S_RY:  st_q <= S_M1;
				S_M1:  st_q <= S_M2;
				S_M2:  st_q <= S_M3;
				S_M3:  st_q <= S_M4;
				S_M4:  st_q <= S_M5;
				S_M5:  st_q <= S_M6;
				S_M6: begin
					if (t_q + CW'(1) < p_w) begin
						t_q  <= t_q + CW'(1);
						st_q <= S_RX;
					end else begin
						k_q  <= kp1;
						st_q <= S_NEXT;
					end
				end
				S_F1:  st_q <= S_F2;
				S_F2:  st_q <= S_F3;
				S_F3:  st_q <= S_F4;
				S_F4:  st_q <= S_DONE;
				S_DONE: begin
					if (out_free) st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		cp_waddr_s1 <= adr(cr_q, cc_q);
		case (st_q)
			S_SR1, S_RY: x_q <= wk_rd_q;
			S_RB:  a_q   <= wk_rd_q;
			S_MA:  b_q   <= wk_rd_q;
			S_MB:  sum_q <= 64'(prod);
			S_MC:  sum_q <= sum_q + 64'(prod);
			S_SQW: if (alu_sts.done) r_q <= alu_res;
			S_DAW: if (alu_sts.done) c_q <= a_q[31] ? -$signed(alu_res[31:0])
				: $signed(alu_res[31:0]);
			S_DBW: if (alu_sts.done) s_q <= b_q[31] ? -$signed(alu_res[31:0])
				: $signed(alu_res[31:0]);
			S_M1:  y_q    <= wk_rd_q;
			S_M2:  acc_q  <= prod;
			S_M3:  accx_q <= acc_q + prod;
			S_M4:  acc_q  <= prod;
			S_M5:  acc_q  <= acc_q - prod;
			S_F2:  d1_q   <= wk_rd_q;
			S_F3:  od_q   <= wk_rd_q;
			S_F4:  d2_q   <= wk_rd_q;
			default: ;
		endcase
		if (st_q == S_DONE && out_free) begin
			out_d1_q <= fail_q ? '0 : d1_q;
			out_od_q <= fail_q ? '0 : od_q;
			out_d2_q <= fail_q ? '0 : d2_q;
			ok_q     <= !fail_q && ($signed(d1_q) > 0) && ($signed(d2_q) > 0);
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign diag_first  = out_d1_q;
	assign off_diag    = out_od_q;
	assign diag_second = out_d2_q;
	assign ok          = ok_q;

endmodule

/* design/ctpp_alu.sv */
// shared arithmetic unit: registered 32x32 multiplier, bit-serial root and divider
// depends on ctpp_pkg
module ctpp_alu (
	input  logic                clk,
	input  logic                arst_n,
	input  ctpp_pkg::alu_req_t  req,
	input  logic [63:0]         num,
	input  logic [32:0]         den,
	input  logic signed [31:0]  mul_x,
	input  logic signed [31:0]  mul_y,
	output logic signed [63:0]  prod,
	output logic [32:0]         res,
	output ctpp_pkg::alu_sts_t  sts
);
	import ctpp_pkg::*;

	typedef enum logic [3:0] {
		A_IDLE = 4'b0001,
		A_SQRT = 4'b0010,
		A_SRND = 4'b0100,
		A_DIV  = 4'b1000
	} alu_state_t;

	alu_state_t         st_q;
	logic [4:0]         cnt_q;
	logic               done_q;
	logic [63:0]        n_q, r_q, bit_q;
	logic [32:0]        rem_q, den_q, res_q;
	logic [31:0]        lo_q, quo_q;
	logic signed [63:0] prod_q;
	logic [63:0]        trial;
	logic               sq_ge;
	logic [33:0]        rem_n;
	logic               dv_ge;

	assign trial = r_q + bit_q;
	assign sq_ge = n_q >= trial;
	assign rem_n = {rem_q, lo_q[31]};
	assign dv_ge = rem_n >= {1'b0, den_q};

	always_ff @(posedge clk) begin
		prod_q <= mul_x * mul_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= A_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			// done pulses after the rounding step or the last divide step
			done_q <= (st_q == A_SRND) || ((st_q == A_DIV) && (cnt_q == 5'd0));
			case (st_q)
				A_IDLE: begin
					if (req.start) begin
						cnt_q <= 5'd31;
						st_q  <= (req.op == OP_SQRT) ? A_SQRT : A_DIV;
					end
				end
				A_SQRT: begin
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) st_q <= A_SRND;
				end
				A_SRND: begin
					st_q <= A_IDLE;
				end
				A_DIV: begin
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) st_q <= A_IDLE;
				end
				default: st_q <= A_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			A_IDLE: begin
				if (req.start) begin
					n_q   <= num;
					r_q   <= '0;
					bit_q <= 64'h4000_0000_0000_0000;
					rem_q <= {1'b0, num[63:32]};
					lo_q  <= num[31:0];
					den_q <= den;
				end
			end
			A_SQRT: begin
				if (sq_ge) begin
					n_q <= n_q - trial;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			A_SRND: begin
				// round to nearest: remainder above root bumps it
				res_q <= 33'(r_q) + ((n_q > r_q) ? 33'd1 : 33'd0);
			end
			A_DIV: begin
				rem_q <= dv_ge ? 33'(rem_n - {1'b0, den_q}) : rem_n[32:0];
				lo_q  <= {lo_q[30:0], 1'b0};
				quo_q <= {quo_q[30:0], dv_ge};
				if (cnt_q == 5'd0) res_q <= {1'b0, quo_q[30:0], dv_ge};
			end
			default: ;
		endcase
	end

	assign prod     = prod_q;
	assign res      = res_q;
	assign sts.done = done_q;
	assign sts.zero = (res_q == '0);

endmodule

/* design/ctpp_checker.sv */
// port-level checks for the cholesky trailing pair permute block
// depends on cholesky_trailing_pair_permute_assert.svh; bound to the top level
`include "cholesky_trailing_pair_permute_assert.svh"

module ctpp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_stall,
	input logic        func,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input logic [31:0] diag_first,
	input logic [31:0] diag_second,
	input logic        ok
);

	// a stalled result word holds
	`CTPP_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(diag_first) && $stable(ok))

	// a query keeps the block busy on the next cycle
	`CTPP_ASSERT_NEXT(a_query_busy, req_valid && !req_stall && func, req_stall)

	// ok only with both diagonals positive
	`CTPP_ASSERT_NOW(a_ok_pos, rsp_valid && ok, $signed(diag_first) > 0 && $signed(diag_second) > 0)

endmodule

bind cholesky_trailing_pair_permute ctpp_checker u_ctpp_checker (.*);

/* sim/tb_cholesky_trailing_pair_permute.sv */
// testbench for cholesky_trailing_pair_permute: a scoreboard class predicts the
// trailing 2x2 factor of each permutation query, plain tasks drive the requests
// depends only on the block under test
`timescale 1ns / 1ps

module tb_cholesky_trailing_pair_permute;

	localparam bit FUNC_LOAD  = 1'b0;
	localparam bit FUNC_QUERY = 1'b1;
	localparam int DIM        = 8;
	localparam int SETTLE     = 100;
	localparam longint LIMIT  = 64'd40000000;
	localparam int ITEMS      = 2000;
	localparam int Q_ONE      = 32'h0001_0000;

	// one expected result word
	typedef struct {
		int d1;
		int od;
		int d2;
		bit ok;
	} factor_t;

	// predicts the permuted trailing factor and holds the results still owed
	class factor_scoreboard;
		int src[DIM*DIM];
		int wk[DIM*DIM];
		int unsigned dim;
		factor_t owed[$];
		int errors;

		function new();
			foreach (src[n]) src[n] = 0;
			dim = 8;
			errors = 0;
		endfunction

		function int clip(longint v);
			if (v > 64'sd2147483647) return 32'h7fff_ffff;
			if (v < -64'sd2147483648) return 32'h8000_0000;
			return int'(v);
		endfunction

		// shift right, round to nearest, ties away from zero
		function longint rshift_round(longint v, int sh);
			longint unsigned half, m;
			half = 64'd1 << (sh - 1);
			if (v < 0) begin
				m = -v;
				return -longint'((m + half) >> sh);
			end
			return longint'((longint'(v) + half) >> sh);
		endfunction

		function longint unsigned root_round(longint unsigned x);
			longint unsigned res, bv, n;
			res = 0;
			bv = 64'd1 << 62;
			n = x;
			while (bv > n) bv >>= 2;
			while (bv != 0) begin
				if (n >= res + bv) begin
					n -= res + bv;
					res = (res >> 1) + bv;
				end else begin
					res >>= 1;
				end
				bv >>= 2;
			end
			if (x - res * res > res) res++;
			return res;
		endfunction

		// q16.16 over raw radius, to q2.30
		function longint frac_q30(longint a, longint unsigned r);
			longint unsigned m, q;
			m = (a < 0) ? -a : a;
			q = ((m << 30) + r / 2) / r;
			return (a < 0) ? -longint'(q) : longint'(q);
		endfunction

		// swap k and k+1, then rotate back to lower triangular
		function bit swap_rotate(int k);
			int tmp;
			longint a, b, c, s, x, y;
			longint unsigned sq, rad;
			for (int t = 0; t < dim; t++) begin
				tmp = wk[k*DIM+t];
				wk[k*DIM+t] = wk[(k+1)*DIM+t];
				wk[(k+1)*DIM+t] = tmp;
			end
			for (int t = 0; t < dim; t++) begin
				tmp = wk[t*DIM+k];
				wk[t*DIM+k] = wk[t*DIM+k+1];
				wk[t*DIM+k+1] = tmp;
			end
			a = wk[k*DIM+k];
			b = wk[k*DIM+k+1];
			sq = a * a + b * b;
			rad = root_round(sq);
			if (rad == 0) return 0;
			c = frac_q30(a, rad);
			s = frac_q30(b, rad);
			wk[k*DIM+k] = clip(longint'(rad));
			wk[k*DIM+k+1] = 0;
			for (int t = k + 1; t < dim; t++) begin
				x = wk[t*DIM+k];
				y = wk[t*DIM+k+1];
				wk[t*DIM+k] = clip(rshift_round(c * x + s * y, 30));
				wk[t*DIM+k+1] = clip(rshift_round(c * y - s * x, 30));
			end
			return 1;
		endfunction

		function void note_word(bit f, bit [2:0] r, bit [2:0] c, int v,
				bit [2:0] fi, bit [2:0] si);
			factor_t res;
			bit good;
			if (f == FUNC_LOAD) begin
				src[r*DIM+c] = v;
				return;
			end
			res = '{0, 0, 0, 0};
			good = (dim >= 2) && (dim <= DIM) && (fi < si) && (si < dim);
			if (good) begin
				for (int rr = 0; rr < dim; rr++)
					for (int cc = 0; cc < dim; cc++)
						wk[rr*DIM+cc] = src[cc*DIM+rr];
				for (int k = si; k + 1 < dim && good; k++) good = swap_rotate(k);
				for (int k = fi; k + 2 < dim && good; k++) good = swap_rotate(k);
				if (good) begin
					res.d1 = wk[(dim-2)*DIM+dim-2];
					res.od = wk[(dim-1)*DIM+dim-2];
					res.d2 = wk[(dim-1)*DIM+dim-1];
					res.ok = (res.d1 > 0) && (res.d2 > 0);
				end
			end
			owed.push_back(res);
		endfunction

		function void check_result(int d1, int od, int d2, bit okv);
			factor_t e;
			if (owed.size() == 0) begin
				if (errors < 10) $display("unexpected result word %h %h %h %b", d1, od, d2, okv);
				errors++;
				return;
			end
			e = owed.pop_front();
			if (e.d1 !== d1 || e.od !== od || e.d2 !== d2 || e.ok !== okv) begin
				if (errors < 10)
					$display("mismatch exp %h %h %h %b got %h %h %h %b",
						e.d1, e.od, e.d2, e.ok, d1, od, d2, okv);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [3:0] cfg_data = '0;
	logic req_valid = 0;
	logic req_stall;
	logic func = 0;
	logic [2:0] row = '0;
	logic [2:0] col = '0;
	logic signed [31:0] value = '0;
	logic [2:0] first_index = '0;
	logic [2:0] second_index = '0;
	logic rsp_valid;
	logic rsp_stall = 0;
	logic signed [31:0] diag_first, off_diag, diag_second;
	logic ok;

	factor_scoreboard sb = new();
	longint cycles = 0;
	int sent = 0;
	bit no_gaps = 0;
	int stall_mode = 0;

	always #4 clk = ~clk;

	cholesky_trailing_pair_permute dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_data(cfg_data),
		.req_valid(req_valid), .req_stall(req_stall),
		.func(func), .row(row), .col(col), .value(value),
		.first_index(first_index), .second_index(second_index),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.diag_first(diag_first), .off_diag(off_diag), .diag_second(diag_second),
		.ok(ok)
	);

	// run-away guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// result side: check every accepted word, stall in random bursts
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_result(diag_first, off_diag, diag_second, ok);
		if ($urandom_range(0, 299) == 0) stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: rsp_stall <= 1'b0;
			1: rsp_stall <= ($urandom_range(0, 9) < 2);
			2: rsp_stall <= ($urandom_range(0, 9) < 6);
			default: rsp_stall <= ($urandom_range(0, 99) < 3)
				|| (rsp_stall && ($urandom_range(0, 19) != 0));
		endcase
	end

	// mostly short gaps, now and then a long one
	function int pick_gap();
		int u;
		if (no_gaps) return 0;
		u = $urandom_range(0, 99);
		if (u < 65) return 0;
		if (u < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	task automatic send_word(bit f, bit [2:0] r, bit [2:0] c, int v, bit [2:0] fi, bit [2:0] si);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		func <= f;
		row <= r;
		col <= c;
		value <= v;
		first_index <= fi;
		second_index <= si;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		sb.note_word(f, r, c, v, fi, si);
		sent++;
	endtask

	task automatic load(int r, int c, int v);
		send_word(FUNC_LOAD, 3'(r), 3'(c), v, 3'($urandom), 3'($urandom));
	endtask

	task automatic query(int fi, int si);
		send_word(FUNC_QUERY, 3'($urandom), 3'($urandom), int'($urandom), 3'(fi), 3'(si));
	endtask

	// drain all owed results, then let trailing loads settle
	task automatic go_idle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic apply_dim(int n);
		go_idle();
		cfg_we <= 1'b1;
		cfg_data <= 4'(n);
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.dim = n & 4'hf;
		@(posedge clk);
	endtask

	// well-formed factor: positive diagonal, moderate upper entries
	task automatic load_factor(int n, bit dirty_lower);
		for (int r = 0; r < n; r++)
			for (int c = 0; c < n; c++) begin
				if (r == c)
					load(r, c, $urandom_range(Q_ONE / 4, 4 * Q_ONE));
				else if (r < c)
					load(r, c, int'($urandom_range(0, 4 * Q_ONE)) - 2 * Q_ONE);
				else if (dirty_lower)
					load(r, c, ($urandom_range(0, 2) == 0) ? int'($urandom) : 0);
				else
					load(r, c, 0);
			end
	endtask

	initial begin
		int n, fi, si, u;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: zero matrix at reset size is singular
		query(0, 7);
		// bad index orderings
		query(3, 3);
		query(5, 2);
		load_factor(8, 0);
		query(0, 7);
		query(6, 7);
		query(0, 1);
		// extremes of value, negative diagonal
		load(0, 0, 32'h7fff_ffff);
		load(7, 7, 32'h8000_0000);
		load(0, 7, 32'h8000_0000);
		load(3, 3, -Q_ONE);
		query(2, 5);
		query(0, 7);
		// sizes that make every query invalid, then the smallest, then one just too large
		apply_dim(0);
		query(0, 1);
		apply_dim(1);
		query(0, 1);
		apply_dim(15);
		query(0, 1);
		apply_dim(2);
		query(0, 1);
		query(1, 7);
		apply_dim(9);
		query(0, 5);

		// random phases, mostly small sizes
		while (sent < ITEMS) begin
			u = $urandom_range(0, 99);
			if (u < 5) n = $urandom_range(0, 15);
			else if (u < 70) n = $urandom_range(2, 4);
			else if (u < 90) n = $urandom_range(5, 7);
			else n = 8;
			apply_dim(n);
			no_gaps = ($urandom_range(0, 3) == 0);
			if (n >= 2 && n <= DIM) load_factor(n, $urandom_range(0, 5) == 0);
			repeat ($urandom_range(3, 8)) begin
				u = $urandom_range(0, 99);
				if (u < 70 && n >= 2 && n <= DIM) begin
					si = $urandom_range(1, n - 1);
					fi = $urandom_range(0, si - 1);
					query(fi, si);
				end else if (u < 85) begin
					query($urandom, $urandom);
				end else begin
					// noise load, anywhere in the store
					load($urandom, $urandom, $urandom);
				end
				if ($urandom_range(0, 4) == 0 && n >= 2 && n <= DIM)
					load($urandom_range(0, n - 1), $urandom_range(0, n - 1),
						int'($urandom_range(0, 4 * Q_ONE)) - Q_ONE);
			end
		end

		go_idle();
		if (sb.errors == 0 && sb.owed.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

/* sim.f */
+incdir+design
design/ctpp_pkg.sv
design/ctpp_alu.sv
design/cholesky_trailing_pair_permute.sv
design/ctpp_checker.sv
sim/tb_cholesky_trailing_pair_permute.sv
